// ===== hdl/wsfr_pkg.sv =====
package wsfr_pkg;

  // APB register map
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned IDX_W = ADDR_W - 2;
  localparam logic [IDX_W-1:0] REG_MAX_PAYLOAD = 1'b0;
  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd16384;

  // frame header codes
  localparam logic [3:0] OP_CONTINUATION = 4'h0;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  // result status codes
  localparam logic [1:0] STATUS_OK = 2'd0;
  localparam logic [1:0] STATUS_CLOSE = 2'd1;
  localparam logic [1:0] STATUS_UNEXPECTED = 2'd2;
  localparam logic [1:0] STATUS_OVERSIZE = 2'd3;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] payload_byte;
    logic       message_end;
    logic [1:0] status;
  } wsfr_result_t;

endpackage

// ===== hdl/websocket_frame_receiver_top.sv =====
// WebSocket frame receiver.
// Slave stream s_axis_* takes the received byte stream after the opening
// handshake, one byte per beat. Master stream m_axis_* gives at most one
// result per input byte: an unmasked payload byte (tuser bit 0 set), an
// end-of-message marker (tlast), or a status flag in tuser[2:1]
// (close seen, unexpected continuation, oversized frame).
// The APB port holds the maximum payload length register at address 0.
// Throughput is one byte per clock while s_axis_tready is high; each
// byte is parsed by one pass of the header/payload state logic and its
// result lands in the output register, ready the cycle after acceptance.
// A stalled master side holds its beat; s_axis_tready stays high as long
// as the output register is empty or is being emptied in the same cycle.
// Reset returns the parser to the first header byte, clears fragment
// tracking and sets the maximum payload length to 16384. After a close
// frame the block keeps accepting bytes but gives no results until reset.
module websocket_frame_receiver_top import wsfr_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // byte input
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
  // results
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // [7:0] payload_byte
  output logic              m_axis_tlast,   // message_end
  output logic [2:0]        m_axis_tuser    // [0] byte_valid, [2:1] status
);

  logic         [31:0] max_payload;
  logic                accept;
  logic                res_valid;
  wsfr_result_t        res;
  wsfr_result_t        out_res;

  wsfr_apb_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .max_payload_o (max_payload)
  );

  assign accept = s_axis_tvalid && s_axis_tready;

  wsfr_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .rx_byte_i     (s_axis_tdata),
    .max_payload_i (max_payload),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  wsfr_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .res_o       (out_res),
    .ready_i     (m_axis_tready)
  );

  assign m_axis_tdata = out_res.payload_byte;
  assign m_axis_tlast = out_res.message_end;
  assign m_axis_tuser = {out_res.status, out_res.byte_valid};

endmodule

// ===== hdl/wsfr_apb_regs.sv =====
module wsfr_apb_regs import wsfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [31:0]       max_payload_o
);

  logic [31:0]      max_payload_q;
  logic [IDX_W-1:0] reg_idx;
  logic             wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MAX_PAYLOAD_RESET;
    end else if (wr_en && (reg_idx == REG_MAX_PAYLOAD)) begin
      max_payload_q <= pwdata;
    end
  end

  assign prdata        = (reg_idx == REG_MAX_PAYLOAD) ? max_payload_q : 32'd0;
  assign max_payload_o = max_payload_q;

endmodule

// ===== hdl/wsfr_parser.sv =====
module wsfr_parser import wsfr_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         accept_i,
  input  logic [7:0]   rx_byte_i,
  input  logic [31:0]  max_payload_i,
  output logic         res_valid_o,
  output wsfr_result_t res_o
);

  localparam int unsigned CMP_W = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_MASK,
    PH_PAYLOAD,
    PH_STOPPED
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic                   fin_q, fin_d;
  logic                   opnz_q, opnz_d;
  logic                   mask_q, mask_d;
  logic [3:0]             lbl_q, lbl_d;
  logic [LENGTH_BITS-1:0] acc_q, acc_d;
  logic                   big_q, big_d;     // accumulated length exceeds LENGTH_BITS
  logic [LENGTH_BITS-1:0] left_q, left_d;
  logic [31:0]            key_q, key_d;
  logic [1:0]             pos_q, pos_d;
  logic                   infrag_q, infrag_d;
  logic                   discard_q, discard_d;

  logic         do_hdr;
  logic         oversize;
  logic [1:0]   key_sel;
  logic [7:0]   key_byte;
  logic [3:0]   opcode;
  logic [6:0]   len7;
  logic         res_valid;
  wsfr_result_t res;

  assign opcode   = rx_byte_i[3:0];
  assign len7     = rx_byte_i[6:0];
  assign key_sel  = 2'd3 - pos_q;
  assign key_byte = key_q[{key_sel, 3'b000} +: 8];

  always_comb begin
    phase_d   = phase_q;
    fin_d     = fin_q;
    opnz_d    = opnz_q;
    mask_d    = mask_q;
    lbl_d     = lbl_q;
    acc_d     = acc_q;
    big_d     = big_q;
    left_d    = left_q;
    key_d     = key_q;
    pos_d     = pos_q;
    infrag_d  = infrag_q;
    discard_d = discard_q;
    do_hdr    = 1'b0;
    oversize  = 1'b0;
    res_valid = 1'b0;
    res       = '0;

    unique case (phase_q)
      PH_HDR0: begin
        fin_d  = rx_byte_i[7];
        opnz_d = (opcode != OP_CONTINUATION);
        if (opcode == OP_CLOSE) begin
          phase_d    = PH_STOPPED;
          res_valid  = 1'b1;
          res.status = STATUS_CLOSE;
        end else begin
          phase_d   = PH_HDR1;
          discard_d = (opcode == OP_CONTINUATION) && !infrag_q;
          if (discard_d) begin
            res_valid  = 1'b1;
            res.status = STATUS_UNEXPECTED;
          end
        end
      end
      PH_HDR1: begin
        mask_d = rx_byte_i[7];
        key_d  = '0;
        acc_d  = '0;
        big_d  = 1'b0;
        if ((len7 == LEN_CODE_EXT16) || (len7 == LEN_CODE_EXT64)) begin
          lbl_d   = (len7 == LEN_CODE_EXT16) ? 4'd2 : 4'd8;
          phase_d = PH_EXTLEN;
        end else begin
          acc_d = LENGTH_BITS'(len7);
          if (rx_byte_i[7]) begin
            lbl_d   = 4'd4;
            phase_d = PH_MASK;
          end else begin
            do_hdr = 1'b1;
          end
        end
      end
      PH_EXTLEN: begin
        acc_d = {acc_q[LENGTH_BITS-9:0], rx_byte_i};
        big_d = big_q | (|acc_q[LENGTH_BITS-1:LENGTH_BITS-8]);
        lbl_d = lbl_q - 4'd1;
        if (lbl_d == 4'd0) begin
          if (mask_q) begin
            lbl_d   = 4'd4;
            phase_d = PH_MASK;
          end else begin
            do_hdr = 1'b1;
          end
        end
      end
      PH_MASK: begin
        key_d = {key_q[23:0], rx_byte_i};
        lbl_d = lbl_q - 4'd1;
        if (lbl_d == 4'd0) begin
          do_hdr = 1'b1;
        end
      end
      PH_PAYLOAD: begin
        pos_d  = pos_q + 2'd1;
        left_d = left_q - LENGTH_BITS'(1);
        if (left_d == '0) begin
          phase_d = PH_HDR0;
        end
        if (!discard_q) begin
          if ((left_d == '0) && fin_q && !opnz_q) begin
            infrag_d = 1'b0;
          end
          res_valid        = 1'b1;
          res.byte_valid   = 1'b1;
          res.payload_byte = rx_byte_i ^ key_byte;
          res.message_end  = (left_d == '0) && fin_q;
        end
      end
      PH_STOPPED: begin
      end
      default: begin
        phase_d = PH_HDR0;
      end
    endcase

    // header complete: length check, then payload start or, for an empty frame, the next header
    if (do_hdr) begin
      pos_d    = '0;
      oversize = big_d || (CMP_W'(acc_d) > CMP_W'(max_payload_i));
      if (oversize) begin
        discard_d = 1'b1;
        if (!discard_q) begin
          infrag_d   = 1'b0;
          res_valid  = 1'b1;
          res.status = STATUS_OVERSIZE;
        end
        left_d  = big_d ? '1 : acc_d;
        phase_d = (left_d == '0) ? PH_HDR0 : PH_PAYLOAD;
      end else begin
        left_d = acc_d;
        if (!discard_q && opnz_q && !fin_q) begin
          infrag_d = 1'b1;
        end
        if (acc_d != '0) begin
          phase_d = PH_PAYLOAD;
        end else begin
          phase_d = PH_HDR0;
          if (!discard_q && fin_q) begin
            if (!opnz_q) begin
              infrag_d = 1'b0;
            end
            res_valid       = 1'b1;
            res.message_end = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR0;
      fin_q     <= 1'b0;
      opnz_q    <= 1'b0;
      mask_q    <= 1'b0;
      lbl_q     <= '0;
      acc_q     <= '0;
      big_q     <= 1'b0;
      left_q    <= '0;
      key_q     <= '0;
      pos_q     <= '0;
      infrag_q  <= 1'b0;
      discard_q <= 1'b0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      fin_q     <= fin_d;
      opnz_q    <= opnz_d;
      mask_q    <= mask_d;
      lbl_q     <= lbl_d;
      acc_q     <= acc_d;
      big_q     <= big_d;
      left_q    <= left_d;
      key_q     <= key_d;
      pos_q     <= pos_d;
      infrag_q  <= infrag_d;
      discard_q <= discard_d;
    end
  end

  assign res_valid_o = res_valid;
  assign res_o       = res;

endmodule

// ===== hdl/wsfr_out_reg.sv =====
module wsfr_out_reg import wsfr_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic         res_valid_i,
  input  wsfr_result_t res_i,
  output logic         ready_o,
  output logic         valid_o,
  output wsfr_result_t res_o,
  input  logic         ready_i
);

  logic         valid_q;
  wsfr_result_t res_q;

  // load whenever the held beat is gone or leaves this cycle
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= push_i && res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && push_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== test/tb_websocket_frame_receiver_top.sv =====
module tb_websocket_frame_receiver_top;
  timeunit 1ns;
  timeprecision 1ps;
  import wsfr_pkg::*;

  localparam logic [63:0] LEN_LIMIT = 64'h0000_0000_FFFF_FFFF;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SEG_BYTES = 260;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic [2:0] {
    PH_HDR0, PH_HDR1, PH_EXTLEN, PH_MASK, PH_PAYLOAD, PH_STOPPED
  } parse_phase_e;

  typedef struct {
    logic [7:0] data;
    bit         drain;  // hold this beat until all results are back
  } rx_item_t;

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata = '0;    // [7:0] rx_byte
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;         // [7:0] payload_byte
  logic              m_axis_tlast;         // message_end
  logic [2:0]        m_axis_tuser;         // [0] byte_valid, [2:1] status

  websocket_frame_receiver_top #(
    .LENGTH_BITS(32)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------- deframer
  logic [31:0]  max_len_cfg = MAX_PAYLOAD_RESET;
  parse_phase_e ph = PH_HDR0;
  logic         fin_bit = 1'b0;
  logic         op_nz = 1'b0;
  logic         masked = 1'b0;
  logic [3:0]   hdr_left = '0;
  logic [63:0]  len_acc = '0;
  logic [63:0]  bytes_left = '0;
  logic [31:0]  mask_key = '0;
  logic [1:0]   key_pos = '0;
  logic         in_msg = 1'b0;
  logic         discarding = 1'b0;

  wsfr_result_t expected_q[$];
  rx_item_t     rx_bytes_q[$];

  function automatic void push_result(logic vld, logic [7:0] data, logic eom, logic [1:0] st);
    wsfr_result_t r;
    r.byte_valid   = vld;
    r.payload_byte = data;
    r.message_end  = eom;
    r.status       = st;
    expected_q = {expected_q, r};
  endfunction

  function automatic void header_complete();
    logic [63:0] len;
    logic        flagged;
    len = len_acc;
    key_pos = '0;
    if (len > {32'd0, max_len_cfg} || len > LEN_LIMIT) begin
      // skip the payload; an already flagged frame gets no second flag
      flagged = discarding;
      discarding = 1'b1;
      if (!flagged) in_msg = 1'b0;
      bytes_left = (len > LEN_LIMIT) ? LEN_LIMIT : len;
      ph = (bytes_left == 0) ? PH_HDR0 : PH_PAYLOAD;
      if (!flagged) push_result(1'b0, 8'h00, 1'b0, STATUS_OVERSIZE);
      return;
    end
    bytes_left = len;
    if (!discarding && op_nz && !fin_bit) in_msg = 1'b1;
    if (len != 0) begin
      ph = PH_PAYLOAD;
      return;
    end
    ph = PH_HDR0;
    if (discarding || !fin_bit) return;
    if (!op_nz) in_msg = 1'b0;
    push_result(1'b0, 8'h00, 1'b1, STATUS_OK);
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    logic [3:0] op;
    logic [6:0] len7;
    logic [7:0] k;
    logic       eof;
    case (ph)
      PH_STOPPED: ;
      PH_HDR0: begin
        op = b[3:0];
        fin_bit = b[7];
        op_nz = (op != OP_CONTINUATION);
        if (op == OP_CLOSE) begin
          ph = PH_STOPPED;
          push_result(1'b0, 8'h00, 1'b0, STATUS_CLOSE);
        end else begin
          ph = PH_HDR1;
          discarding = !op_nz && !in_msg;
          if (discarding) push_result(1'b0, 8'h00, 1'b0, STATUS_UNEXPECTED);
        end
      end
      PH_HDR1: begin
        len7 = b[6:0];
        masked = b[7];
        mask_key = '0;
        len_acc = '0;
        if (len7 == LEN_CODE_EXT16 || len7 == LEN_CODE_EXT64) begin
          hdr_left = (len7 == LEN_CODE_EXT16) ? 4'd2 : 4'd8;
          ph = PH_EXTLEN;
        end else begin
          len_acc = 64'(len7);
          if (masked) begin
            hdr_left = 4'd4;
            ph = PH_MASK;
          end else begin
            header_complete();
          end
        end
      end
      PH_EXTLEN: begin
        len_acc = {len_acc[55:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 0) begin
          if (masked) begin
            hdr_left = 4'd4;
            ph = PH_MASK;
          end else begin
            header_complete();
          end
        end
      end
      PH_MASK: begin
        mask_key = {mask_key[23:0], b};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == 0) header_complete();
      end
      default: begin
        k = mask_key[8*(3-int'(key_pos)) +: 8];
        key_pos = key_pos + 2'd1;
        bytes_left = (bytes_left - 64'd1) & LEN_LIMIT;
        eof = (bytes_left == 0);
        if (eof) ph = PH_HDR0;
        if (!discarding) begin
          if (eof && fin_bit && !op_nz) in_msg = 1'b0;
          push_result(1'b1, b ^ k, eof && fin_bit, STATUS_OK);
        end
      end
    endcase
  endfunction

  // ------------------------------------------------------------ byte driver
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned bytes_in = 0;
  int unsigned pauses = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        deframe_byte(s_axis_tdata);
        bytes_in++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (rx_bytes_q.size() != 0 && !(rx_bytes_q[0].drain && expected_q.size() != 0)
            && $urandom_range(99) >= send_idle_pct) begin
          if (rx_bytes_q[0].drain) pauses++;
          s_axis_tdata  <= rx_bytes_q[0].data;
          s_axis_tvalid <= 1'b1;
          void'(rx_bytes_q.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------- result checker
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned data_beats = 0;
  int unsigned msg_ends = 0;
  int unsigned flag_cnt[4] = '{0, 0, 0, 0};

  function automatic string fmt_result(wsfr_result_t r);
    return $sformatf("vld=%0b byte=%02h eom=%0b sts=%0d",
                     r.byte_valid, r.payload_byte, r.message_end, r.status);
  endfunction

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk_i) begin : result_check
    wsfr_result_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.byte_valid   = m_axis_tuser[0];
        got.payload_byte = m_axis_tdata;
        got.message_end  = m_axis_tlast;
        got.status       = m_axis_tuser[2:1];
        results_seen++;
        if (got.byte_valid) data_beats++;
        if (got.message_end) msg_ends++;
        flag_cnt[got.status]++;
        if (expected_q.size() == 0) begin
          note_mismatch({"result with nothing expected: ", fmt_result(got)});
        end else begin
          want = expected_q.pop_front();
          if (got !== want)
            note_mismatch({"expected ", fmt_result(want), ", got ", fmt_result(got)});
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- watchdog
  int unsigned stall_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, expected_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------- stimulus
  int unsigned seg_bytes = 0;

  task automatic push_byte(input logic [7:0] b, input bit drain = 1'b0);
    rx_item_t it;
    it.data  = b;
    it.drain = drain;
    rx_bytes_q = {rx_bytes_q, it};
    seg_bytes++;
  endtask

  // form: 0 = 7-bit length, 1 = 16-bit extended, 2 = 64-bit extended
  task automatic push_frame(input bit fin, input logic [3:0] op, input bit msk,
                            input int unsigned len, input int unsigned form,
                            input bit drain = 1'b0);
    logic [31:0] mk;
    int          i;
    mk = $urandom();
    push_byte({fin, 3'($urandom_range(7)), op}, drain);
    case (form)
      0: push_byte({msk, 7'(len)});
      1: begin
        push_byte({msk, LEN_CODE_EXT16});
        push_byte(8'(len >> 8));
        push_byte(8'(len));
      end
      default: begin
        push_byte({msk, LEN_CODE_EXT64});
        repeat (4) push_byte(8'h00);
        for (i = 3; i >= 0; i--) push_byte(8'(len >> (8 * i)));
      end
    endcase
    if (msk) for (i = 0; i < 4; i++) push_byte(mk[31-8*i -: 8]);
    for (i = 0; i < int'(len); i++) push_byte(8'($urandom()));
  endtask

  function automatic logic [3:0] pick_opcode();
    logic [3:0] op;
    do op = 4'($urandom_range(15, 1)); while (op == OP_CLOSE);
    return op;
  endfunction

  task automatic rand_frame(input bit fin, input logic [3:0] op, input bit drain = 1'b0);
    int unsigned len, form, r;
    r = $urandom_range(99);
    form = 0;
    if (r < 60) begin
      len = $urandom_range(8);
    end else if (r < 68) begin
      len = $urandom_range(40, 9);
    end else if (r < 70) begin
      len = 125;
    end else if (r < 80) begin
      form = 1;
      len = $urandom_range(300);
    end else if (r < 88) begin
      form = 2;
      len = $urandom_range(300);
    end else if (max_len_cfg <= 300) begin
      // right at the length limit or one past it
      len = max_len_cfg + $urandom_range(1);
      form = $urandom_range(2);
      if (form == 0 && len > 125) form = 1;
    end else begin
      len = $urandom_range(8);
    end
    push_frame(fin, op, $urandom_range(3) != 0, len, form, drain);
  endtask

  task automatic gen_message(input bit drain);
    int unsigned r, n;
    r = $urandom_range(99);
    if (r < 50) begin
      rand_frame(1'b0, 4'($urandom_range(2, 1)), drain);
      n = $urandom_range(3);
      repeat (n) begin
        if ($urandom_range(3) == 0) rand_frame(1'b1, pick_opcode());
        if ($urandom_range(4) == 0) rand_frame(1'b0, pick_opcode());
        rand_frame(1'b0, OP_CONTINUATION);
      end
      rand_frame(1'b1, OP_CONTINUATION);
    end else if (r < 80) begin
      rand_frame(1'b1, pick_opcode(), drain);
    end else if (r < 88) begin
      rand_frame($urandom_range(1), OP_CONTINUATION, drain);
    end else if (r < 95) begin
      rand_frame(1'b0, pick_opcode(), drain);
    end else begin
      rand_frame($urandom_range(1), 4'($urandom_range(15)) == OP_CLOSE ? OP_CONTINUATION
                                                                        : pick_opcode(), drain);
    end
  endtask

  task automatic run_segment(input int unsigned target);
    bit paused;
    paused = 1'b0;
    seg_bytes = 0;
    while (seg_bytes < target) begin
      gen_message(!paused && seg_bytes >= target / 2);
      if (seg_bytes >= target / 2) paused = 1'b1;
    end
  endtask

  task automatic wait_idle();
    while (rx_bytes_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max_len(input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MAX_PAYLOAD, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    max_len_cfg = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== value)
      note_mismatch($sformatf("max length readback %08h, wrote %08h", prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    while (!rst_ni) @(posedge clk_i);
    @(posedge clk_i);
    send_idle_pct = 25;
    recv_idle_pct = 85;

    // masked text frame carrying 00 and ff
    push_byte(8'h81);
    push_byte(8'h83);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'hA5);
    push_byte(8'h3C);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h7E);
    // final fragment with no message open
    push_frame(1'b1, OP_CONTINUATION, 1'b0, 0, 0);
    // start, empty continuation, ping inside the message, final
    push_frame(1'b0, 4'h1, 1'b0, 1, 0);
    push_frame(1'b0, OP_CONTINUATION, 1'b0, 0, 0);
    push_frame(1'b1, 4'h9, 1'b0, 1, 0);
    push_frame(1'b1, OP_CONTINUATION, 1'b0, 1, 0);
    // zero-length single frame
    push_frame(1'b1, 4'h2, 1'b0, 0, 0);
    wait_idle();
    run_segment(SEG_BYTES);
    wait_idle();

    write_max_len(32'd0);
    // every nonempty frame is oversized, also inside a message
    push_frame(1'b0, 4'h1, 1'b0, 0, 0);
    push_frame(1'b1, 4'h2, 1'b1, 1, 0);
    push_frame(1'b1, OP_CONTINUATION, 1'b0, 0, 0);
    run_segment(SEG_BYTES);
    wait_idle();

    send_idle_pct = 85;
    recv_idle_pct = 25;
    write_max_len(32'd12);
    run_segment(SEG_BYTES);
    wait_idle();
    write_max_len(32'hFFFF_FFFF);
    run_segment(SEG_BYTES);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_max_len(32'd40);
    run_segment(SEG_BYTES);
    // close frame; the bytes behind it must give nothing
    push_byte(8'h88);
    repeat (8) push_byte(8'($urandom()));
    wait_idle();
    repeat (10) @(posedge clk_i);

    $display("run: %0d bytes in, %0d results (%0d payload bytes, %0d message ends), %0d pauses",
             bytes_in, results_seen, data_beats, msg_ends, pauses);
    $display("flags: %0d close, %0d stray fragment, %0d oversized; max length 16384/0/12/max/40",
             flag_cnt[STATUS_CLOSE], flag_cnt[STATUS_UNEXPECTED], flag_cnt[STATUS_OVERSIZE]);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule
